@@ rtl/core/assert_macros.svh @@
// assertion macros used by the sieve engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LPS_ASSERT(label, clk, rst_n, prop)
`define LPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/lps_pkg.sv @@
// shared constants and types of the linear prime sieve
package lps_pkg;

    localparam int MAX_LIMIT_DEF  = 65536;
    localparam int MAX_PRIMES_DEF = 8192;

    localparam int LIMIT_W  = 16;
    localparam int COUNT_W  = 13;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_RDMAP = 7'b0000100,
        ST_CHK   = 7'b0001000,
        ST_RDP   = 7'b0010000,
        ST_MARK  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } lps_state_t;

    typedef struct packed {
        logic ready;
        logic done;
    } lps_stat_t;

endpackage

@@ rtl/core/lps_engine.sv @@
// sieve sequencer with the factor map and prime list memories
`include "assert_macros.svh"

module lps_engine #(
    parameter int MAX_LIMIT  = lps_pkg::MAX_LIMIT_DEF,
    parameter int MAX_PRIMES = lps_pkg::MAX_PRIMES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [$clog2(MAX_LIMIT)-1:0]  top_val,
    input  logic                          out_free,
    output lps_pkg::lps_stat_t            stat,
    output logic [lps_pkg::COUNT_W-1:0]   count
);

    localparam int NW = $clog2(MAX_LIMIT);
    localparam int AW = $clog2(MAX_PRIMES);
    localparam int KW = $clog2(MAX_PRIMES + 1);
    localparam int PW = 2 * NW;

    // map entry: zero when unmarked, else list index of smallest factor plus one
    logic [KW-1:0] map_mem [MAX_LIMIT];
    logic [NW-1:0] list_mem [MAX_PRIMES];

    logic [KW-1:0] map_rdata_reg;
    logic [NW-1:0] list_rdata_reg;

    lps_pkg::lps_state_t state_reg, state_next;
    logic [NW-1:0]                i_reg, i_next;
    logic [NW-1:0]                top_reg, top_next;
    logic [KW-1:0]                k_reg, k_next;
    logic [KW-1:0]                stored_reg, stored_next;
    logic [KW-1:0]                spf_k_reg, spf_k_next;
    logic                         spf_ok_reg, spf_ok_next;
    logic [lps_pkg::COUNT_W-1:0]  found_reg, found_next;

    logic          map_we;
    logic [NW-1:0] map_waddr;
    logic [KW-1:0] map_wdata;
    logic          list_we;
    logic [AW-1:0] list_waddr;
    logic [AW-1:0] list_raddr;
    logic [KW-1:0] kp1;
    logic [PW-1:0] prod;
    logic          mark_we;
    logic          done;

    assign kp1  = k_reg + 1'b1;
    assign prod = PW'(list_rdata_reg) * PW'(i_reg);
    assign list_raddr = (state_reg == lps_pkg::ST_MARK) ? kp1[AW-1:0] : k_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[list_waddr] <= i_reg;
        end
        list_rdata_reg <= list_mem[list_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        top_next    = top_reg;
        k_next      = k_reg;
        stored_next = stored_reg;
        spf_k_next  = spf_k_reg;
        spf_ok_next = spf_ok_reg;
        found_next  = found_reg;
        map_we      = 1'b0;
        map_waddr   = i_reg;
        map_wdata   = '0;
        list_we     = 1'b0;
        list_waddr  = stored_reg[AW-1:0];
        mark_we     = 1'b0;
        done        = 1'b0;

        unique case (state_reg)
            lps_pkg::ST_CLEAR:
            begin
                map_we = 1'b1;
                if (i_reg == NW'(MAX_LIMIT - 1))
                begin
                    state_next = lps_pkg::ST_IDLE;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            lps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    top_next    = top_val;
                    i_next      = NW'(2);
                    found_next  = '0;
                    stored_next = '0;
                    if (top_val < NW'(2))
                    begin
                        state_next = lps_pkg::ST_FIN;
                    end
                    else
                    begin
                        state_next = lps_pkg::ST_RDMAP;
                    end
                end
            end
            lps_pkg::ST_RDMAP:
            begin
                state_next = lps_pkg::ST_CHK;
            end
            lps_pkg::ST_CHK:
            begin
                // clear on read keeps the map zero between requests
                map_we = 1'b1;
                k_next = '0;
                if (map_rdata_reg == '0)
                begin
                    if (found_reg != lps_pkg::COUNT_MAX)
                    begin
                        found_next = found_reg + 1'b1;
                    end
                    if (stored_reg < KW'(MAX_PRIMES))
                    begin
                        list_we     = 1'b1;
                        spf_k_next  = stored_reg;
                        spf_ok_next = 1'b1;
                        stored_next = stored_reg + 1'b1;
                    end
                    else
                    begin
                        spf_ok_next = 1'b0;
                    end
                end
                else
                begin
                    spf_k_next  = map_rdata_reg - 1'b1;
                    spf_ok_next = 1'b1;
                end
                state_next = lps_pkg::ST_RDP;
            end
            lps_pkg::ST_RDP:
            begin
                if (k_reg < stored_reg)
                begin
                    state_next = lps_pkg::ST_MARK;
                end
                else if (i_reg == top_reg)
                begin
                    state_next = lps_pkg::ST_FIN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = lps_pkg::ST_RDMAP;
                end
            end
            lps_pkg::ST_MARK:
            begin
                if (prod <= PW'(top_reg))
                begin
                    mark_we   = 1'b1;
                    map_we    = 1'b1;
                    map_waddr = prod[NW-1:0];
                    map_wdata = kp1;
                end
                // stop past the limit, at the smallest factor of i or at the end of the prime list
                if (mark_we && !(spf_ok_reg && k_reg == spf_k_reg) && kp1 < stored_reg)
                begin
                    k_next = kp1;
                end
                else if (i_reg == top_reg)
                begin
                    state_next = lps_pkg::ST_FIN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = lps_pkg::ST_RDMAP;
                end
            end
            lps_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = lps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lps_pkg::ST_CLEAR;
            i_reg      <= '0;
            top_reg    <= '0;
            k_reg      <= '0;
            stored_reg <= '0;
            spf_k_reg  <= '0;
            spf_ok_reg <= 1'b0;
            found_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            top_reg    <= top_next;
            k_reg      <= k_next;
            stored_reg <= stored_next;
            spf_k_reg  <= spf_k_next;
            spf_ok_reg <= spf_ok_next;
            found_reg  <= found_next;
        end
    end

    assign stat.ready = (state_reg == lps_pkg::ST_IDLE);
    assign stat.done  = done;
    assign count      = found_reg;

    `LPS_ASSERT(a_mark_range, clk, rst_n, mark_we |-> (map_waddr <= top_reg && map_waddr > i_reg))
    `LPS_ASSERT(a_k_bound, clk, rst_n, (state_reg == lps_pkg::ST_MARK) |-> (k_reg < stored_reg))
    `LPS_ASSERT(a_list_room, clk, rst_n, list_we |-> (stored_reg < KW'(MAX_PRIMES)))
    `LPS_ASSERT_NEXT(a_done_idle, clk, rst_n, done, state_reg == lps_pkg::ST_IDLE)

endmodule

@@ rtl/core/linear_prime_sieve.sv @@
// linear prime sieve top level: stream ports, limit clamp and result register
// per word: each number 2..limit passes a map read, a check and a prime list read, then one
// mark step per listed prime tried on it, and the result is loaded; limits below 2 go straight to it
// flow: one word at a time, the next word is taken after the result is loaded
// reset: asynchronous active low, then a sweep over all MAX_LIMIT entries clears the factor map
// while s_tready stays low

module linear_prime_sieve #(
    parameter int MAX_LIMIT  = lps_pkg::MAX_LIMIT_DEF,
    parameter int MAX_PRIMES = lps_pkg::MAX_PRIMES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [lps_pkg::IN_W-1:0]   s_tdata,   // limit[15:0]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [lps_pkg::OUT_W-1:0]  m_tdata    // prime_count[12:0], zero pad
);

    localparam int NW = $clog2(MAX_LIMIT);
    localparam int CW = (NW > lps_pkg::LIMIT_W) ? NW : lps_pkg::LIMIT_W;

    lps_pkg::lps_stat_t           stat;
    logic [lps_pkg::COUNT_W-1:0]  count;
    logic [CW-1:0]                lim_ext;
    logic [CW-1:0]                lim_sat;
    logic                         accept;
    logic                         out_free;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [lps_pkg::COUNT_W-1:0]  count_reg, count_next;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = stat.ready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign lim_ext = CW'(s_tdata[lps_pkg::LIMIT_W-1:0]);
    assign lim_sat = (lim_ext > CW'(MAX_LIMIT - 1)) ? CW'(MAX_LIMIT - 1) : lim_ext;

    lps_engine #(
        .MAX_LIMIT  (MAX_LIMIT),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .top_val  (lim_sat[NW-1:0]),
        .out_free (out_free),
        .stat     (stat),
        .count    (count)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        count_next    = count_reg;
        if (stat.done)
        begin
            m_tvalid_next = 1'b1;
            count_next    = count;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lps_pkg::OUT_W'(count_reg);

endmodule

@@ bench/lps_sieve_checker.sv @@
// checker for the linear prime sieve: predicts each prime count and compares the result words
module lps_sieve_checker #(
    parameter int MAX_LIMIT  = lps_pkg::MAX_LIMIT_DEF,
    parameter int MAX_PRIMES = lps_pkg::MAX_PRIMES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [lps_pkg::IN_W-1:0]   s_tdata,   // limit[15:0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [lps_pkg::OUT_W-1:0]  m_tdata,   // prime_count[12:0], zero pad
    output int                         fail_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [lps_pkg::LIMIT_W-1:0] limit;
        logic [lps_pkg::COUNT_W-1:0] count;
    } sieve_job_t;

    sieve_job_t  pending_counts [$];
    bit          marked [MAX_LIMIT];
    int unsigned prime_tab [MAX_PRIMES];

    function automatic logic [lps_pkg::COUNT_W-1:0] count_primes(
        input logic [lps_pkg::LIMIT_W-1:0] lim
    );
        int unsigned top;
        int unsigned n;
        int unsigned k;
        int unsigned p;
        int unsigned stored;
        int unsigned found;
        top    = lim;
        stored = 0;
        found  = 0;
        if (top >= MAX_LIMIT)
            top = MAX_LIMIT - 1;
        if (top < 2)
            return '0;
        for (n = 0; n <= top; n++)
            marked[n] = 1'b0;
        for (n = 2; n <= top; n++)
        begin
            if (!marked[n])
            begin
                if (stored < MAX_PRIMES)
                begin
                    prime_tab[stored] = n;
                    stored++;
                end
                if (found < lps_pkg::COUNT_MAX)
                    found++;
            end
            // each composite is marked once, by its smallest prime factor
            for (k = 0; k < stored; k++)
            begin
                p = prime_tab[k];
                if (p > top / n)
                    break;
                marked[p * n] = 1'b1;
                if (n % p == 0)
                    break;
            end
        end
        return found[lps_pkg::COUNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int lim, input int got,
                                   input int want);
        $display("%0t: mismatch on %s for limit %0d: got %0d, expected %0d",
                 $time, what, lim, got, want);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        sieve_job_t job;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_counts.size() == 0)
                    report_mismatch("unexpected word", -1, m_tdata, 0);
                else
                begin
                    job = pending_counts.pop_front();
                    if (m_tdata[lps_pkg::COUNT_W-1:0] !== job.count)
                        report_mismatch("prime_count", job.limit,
                                        m_tdata[lps_pkg::COUNT_W-1:0], job.count);
                    if (m_tdata[lps_pkg::OUT_W-1:lps_pkg::COUNT_W] !== '0)
                        report_mismatch("pad bits", job.limit,
                                        m_tdata[lps_pkg::OUT_W-1:lps_pkg::COUNT_W], 0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                job.limit = s_tdata[lps_pkg::LIMIT_W-1:0];
                job.count = count_primes(job.limit);
                pending_counts.push_back(job);
            end
            outstanding <= pending_counts.size();
        end
    end

endmodule

@@ bench/tb_linear_prime_sieve.sv @@
// testbench top for the linear prime sieve: stimulus, flow control and verdict
module tb_linear_prime_sieve;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_LIMIT    = lps_pkg::MAX_LIMIT_DEF;
    localparam int MAX_PRIMES   = lps_pkg::MAX_PRIMES_DEF;
    localparam int LIMIT_W      = lps_pkg::LIMIT_W;
    localparam int RANDOM_ITEMS = 76;
    localparam int MAX_IDLE     = 16;
    localparam int HOLD_AT      = 30;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 100;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [lps_pkg::IN_W-1:0]  s_tdata  = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [lps_pkg::OUT_W-1:0] m_tdata;

    int      fail_count;
    int      outstanding;
    int      limits_sent   = 0;
    int      results_taken = 0;
    longint  cycle_count   = 0;
    longint  cycle_budget  = 4 * MAX_LIMIT + HOLD_CYCLES + 20000;

    int unsigned directed_limits [$] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 12, 25, 30, 31,
                                         97, 100, 121, 128, 255, 256, 1000, 4096, 65535};

    linear_prime_sieve #(
        .MAX_LIMIT  (MAX_LIMIT),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lps_sieve_checker #(
        .MAX_LIMIT  (MAX_LIMIT),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_budget)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_limit(input logic [lps_pkg::LIMIT_W-1:0] lim);
        int gap;
        gap = (limits_sent >= 45 && limits_sent < 65) ? 0 : $urandom_range(0, MAX_IDLE);
        cycle_budget += 24 * lim + 300;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lim;
        do
            @(posedge clk);
        while (!(s_tready === 1'b1));
        limits_sent++;
    endtask

    // receiver, with one long hold-off so the block backs up into its input
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (results_taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (results_taken >= 50 && results_taken < 70)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_IDLE);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid === 1'b1));
            results_taken++;
        end
    end

    initial
    begin
        int unsigned pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_limits[i])
            send_limit(LIMIT_W'(directed_limits[i]));

        // mostly small limits, some medium and a few larger ones
        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_limit(LIMIT_W'($urandom_range(0, 255)));
            else if (pick < 96)
                send_limit(LIMIT_W'($urandom_range(256, 2047)));
            else
                send_limit(LIMIT_W'($urandom_range(4096, 12000)));
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_engine.sv
rtl/core/linear_prime_sieve.sv
bench/lps_sieve_checker.sv
bench/tb_linear_prime_sieve.sv
